// ----- hw/rtl/crf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types and codes for the command frame receiver.
// ----------------------------------------------------------------------------
package crf_pkg;

	localparam int FRAME_BYTES = 6;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;
	typedef logic [1:0]  reply_t;
	typedef logic [2:0]  mode_t;
	typedef logic [1:0]  reg_idx_t;

	// frame bytes, index 0 is the oldest
	typedef logic [FRAME_BYTES-1:0][7:0] window_t;

	// reply codes
	localparam reply_t REPLY_ACK        = 2'd0;
	localparam reply_t REPLY_CRC_NACK   = 2'd1;
	localparam reply_t REPLY_FRAME_NACK = 2'd2;

	// modes
	localparam mode_t MODE_INITIAL  = 3'd0;
	localparam mode_t MODE_COUNT    = 3'd1;
	localparam mode_t MODE_TRANSFER = 3'd2;
	localparam mode_t MODE_FINISH   = 3'd3;
	localparam mode_t MODE_INFO     = 3'd4;

	// command bytes
	localparam byte_t CMD_COUNT    = 8'h01;
	localparam byte_t CMD_TRANSFER = 8'h02;
	localparam byte_t CMD_FINISH   = 8'h08;
	localparam byte_t CMD_INFO     = 8'h09;

	localparam word_t CRC_POLY = 16'h1021;

	// register indexes
	localparam reg_idx_t REG_HEAD_BYTE = 2'd0;
	localparam reg_idx_t REG_TAIL_BYTE = 2'd1;
	localparam reg_idx_t REG_TIMEOUT   = 2'd2;
	localparam reg_idx_t REG_CRC_SEED  = 2'd3;

	// register reset values
	localparam byte_t HEAD_BYTE_RST = 8'h26;
	localparam byte_t TAIL_BYTE_RST = 8'h0A;
	localparam word_t TIMEOUT_RST   = 16'd3000;
	localparam word_t CRC_SEED_RST  = 16'h1D0F;

	typedef struct packed {
		byte_t head_byte;
		byte_t tail_byte;
		word_t timeout_ticks;
		word_t crc_seed;
	} cfg_t;

	// outcome of one item: result fields and next state
	typedef struct packed {
		logic   emit;
		reply_t reply;
		mode_t  mode_next;
		logic   mode_changed;
		logic   power_off;
		word_t  idle_next;
	} step_t;

endpackage

`default_nettype wire

// ----- hw/rtl/command_frame_receiver_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_receiver_top
// Command frame receiver: 6-byte frame window, CRC-16 check, mode control.
// ----------------------------------------------------------------------------
// Takes one item per clock (a received byte, or a millisecond tick when
// s_tuser is high) and answers with at most one reply item. An accepted item
// is held in an input register, evaluated in one pass, and its reply lands in
// the output register; the path between those two registers (byte shift,
// two-byte CRC, command decode) sets the clock. The input side keeps taking
// items while a reply waits on m_tready, as long as items produce no further
// reply. Configuration is to be written through cfg_we/cfg_addr/cfg_wdata
// while no item is in flight; the block does not enforce this. Reset values
// are head byte 0x26, tail byte 0x0A, timeout 3000 ticks, CRC seed 0x1D0F.
// ----------------------------------------------------------------------------
module command_frame_receiver_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input items
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
	input  wire logic                s_tuser,   // [0] action (1 = tick)
	// reply items
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,   // [2:0] mode, [3] mode_changed,
	                                            // [4] power_off, [7:5] zero
	output logic [1:0]               m_tuser,   // [1:0] reply
	// configuration
	input  wire logic                cfg_we,
	input  wire crf_pkg::reg_idx_t   cfg_addr,
	input  wire crf_pkg::word_t      cfg_wdata
);
	import crf_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	logic    action_s1;
	byte_t   byte_s1;
	window_t win_q;
	window_t win_next;
	mode_t   mode_q;
	word_t   idle_q;
	step_t   step;
	logic    advance;
	logic    out_valid_q;
	reply_t  reply_q;
	mode_t   out_mode_q;
	logic    changed_q;
	logic    off_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte     <= HEAD_BYTE_RST;
			cfg_q.tail_byte     <= TAIL_BYTE_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.crc_seed      <= CRC_SEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HEAD_BYTE: cfg_q.head_byte     <= cfg_wdata[7:0];
				REG_TAIL_BYTE: cfg_q.tail_byte     <= cfg_wdata[7:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_wdata;
				REG_CRC_SEED:  cfg_q.crc_seed      <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// stage 1 moves on when the output register can take a reply or its item emits none
	assign advance  = valid_s1 && (!out_valid_q || m_tready || !step.emit);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	crf_frame_eval u_eval (
		.action   (action_s1),
		.rx_byte  (byte_s1),
		.win      (win_q),
		.mode     (mode_q),
		.idle     (idle_q),
		.cfg      (cfg_q),
		.win_next (win_next),
		.step     (step)
	);

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			mode_q <= MODE_INITIAL;
			idle_q <= '0;
		end else if (advance) begin
			win_q  <= win_next;
			mode_q <= step.mode_next;
			idle_q <= step.idle_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			reply_q    <= step.reply;
			out_mode_q <= step.mode_next;
			changed_q  <= step.mode_changed;
			off_q      <= step.power_off;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = reply_q;
	assign m_tdata  = {3'b000, off_q, changed_q, out_mode_q};

	// a pending reply always shows the current mode
	a_mode_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_mode_q == mode_q))
		else $error("reply mode differs from current mode");

	// only an ACK changes the mode
	a_changed_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && changed_q) |-> (reply_q == REPLY_ACK))
		else $error("mode change on a NACK");

	// power off only with finish mode set by this reply
	a_power_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && off_q) |-> (changed_q && out_mode_q == MODE_FINISH))
		else $error("power off without finish ACK");

	// mode never leaves its code range
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= MODE_INFO)
		else $error("mode out of range");

	// a waiting reply is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && valid_s1 && step.emit) |-> !advance)
		else $error("reply overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/crf_frame_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crf_frame_eval
// Single-pass evaluation of one item: window shift, frame match, CRC-16
// check, command decode and tick timeout.
// ----------------------------------------------------------------------------
module crf_frame_eval (
	input  wire logic             action,
	input  wire crf_pkg::byte_t   rx_byte,
	input  wire crf_pkg::window_t win,
	input  wire crf_pkg::mode_t   mode,
	input  wire crf_pkg::word_t   idle,
	input  wire crf_pkg::cfg_t    cfg,
	output crf_pkg::window_t      win_next,
	output crf_pkg::step_t        step
);
	import crf_pkg::*;

	// one byte through the CRC register, MSB first
	function automatic word_t crc_byte(input word_t crc, input byte_t b);
		word_t c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	window_t     shifted;
	word_t       crc_local;
	word_t       crc_frame;
	logic [16:0] tick_next;
	logic        frame_hit;
	logic        cmd_ok;
	mode_t       cmd_mode;

	// newest byte enters at the top
	assign shifted  = {rx_byte, win[FRAME_BYTES-1:1]};
	assign win_next = action ? win : shifted;

	assign frame_hit = (shifted[0] == cfg.head_byte) &&
	                   (shifted[FRAME_BYTES-1] == cfg.tail_byte);

	assign crc_local = crc_byte(crc_byte(cfg.crc_seed, shifted[1]), shifted[2]);
	assign crc_frame = {shifted[3], shifted[4]};
	assign tick_next = {1'b0, idle} + 17'd1;

	// command decode
	always_comb begin
		cmd_ok   = 1'b1;
		cmd_mode = MODE_INITIAL;
		unique case (shifted[1])
			CMD_COUNT:    cmd_mode = MODE_COUNT;
			CMD_TRANSFER: cmd_mode = MODE_TRANSFER;
			CMD_FINISH:   cmd_mode = MODE_FINISH;
			CMD_INFO:     cmd_mode = MODE_INFO;
			default:      cmd_ok   = 1'b0;
		endcase
	end

	// outcome
	always_comb begin
		step.emit         = 1'b0;
		step.reply        = REPLY_FRAME_NACK;
		step.mode_next    = mode;
		step.mode_changed = 1'b0;
		step.power_off    = 1'b0;
		step.idle_next    = idle;
		if (action) begin
			if (tick_next >= {1'b0, cfg.timeout_ticks}) begin
				step.emit      = 1'b1;
				step.idle_next = '0;
			end else begin
				step.idle_next = tick_next[15:0];
			end
		end else if (frame_hit) begin
			step.emit      = 1'b1;
			step.idle_next = '0;
			if (shifted[2] != 8'h00) begin
				step.reply = REPLY_FRAME_NACK;
			end else if (crc_local != crc_frame) begin
				step.reply = REPLY_CRC_NACK;
			end else if (cmd_ok) begin
				step.reply        = REPLY_ACK;
				step.mode_next    = cmd_mode;
				step.mode_changed = 1'b1;
				step.power_off    = (shifted[1] == CMD_FINISH);
			end
		end
	end

endmodule

`default_nettype wire
